// ----- rtl/lfu_pkg.sv -----
`default_nettype none

package lfu_pkg;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_ABSENT    = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	// operation codes carried on s_tuser
	localparam logic FUNC_TOUCH  = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [31:0] STAMP_LAST = 32'hFFFF_FFFF;

	// one heap slot
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] count;
		logic [31:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_RM_RD,
		S_RM_LD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_TOP,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan;
		logic       hit;
		logic       status_wr;
		logic [1:0] status_code;
		logic       insert;
		logic       rm_read;
		logic       rm_load;
		logic       up_read;
		logic       up_move;
		logic       down_read;
		logic       down_move;
		logic       place;
		logic       top_read;
		logic       out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic miss;
		logic full;
		logic exhausted;
		logic remove;
		logic pos_zero;
		logic pos_is_last;
		logic up_before;
		logic left_in;
		logic down_before;
		logic moved;
		logic out_free;
	} sts_t;

	// heap order: lower count first, earlier stamp on equal counts
	function automatic logic key_before(input entry_t a, input entry_t b);
		logic r;
		if (a.count != b.count) begin
			r = a.count < b.count;
		end else begin
			r = a.stamp < b.stamp;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
`default_nettype none

module lfu_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire lfu_pkg::sts_t sts,
	output lfu_pkg::cmd_t cmd
);

	lfu_pkg::state_t state_q;
	lfu_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfu_pkg::S_IDLE: begin
				if (s_tvalid) state_d = lfu_pkg::S_SCAN;
			end
			lfu_pkg::S_SCAN: begin
				if (sts.hit) begin
					state_d = sts.remove ? lfu_pkg::S_RM_RD : lfu_pkg::S_DN_RD;
				end else if (sts.miss) begin
					if (sts.remove || sts.full || sts.exhausted) begin
						state_d = lfu_pkg::S_TOP;
					end else begin
						state_d = lfu_pkg::S_UP_RD;
					end
				end
			end
			lfu_pkg::S_RM_RD: state_d = lfu_pkg::S_RM_LD;
			lfu_pkg::S_RM_LD: begin
				state_d = sts.pos_is_last ? lfu_pkg::S_TOP : lfu_pkg::S_UP_RD;
			end
			lfu_pkg::S_UP_RD, lfu_pkg::S_UP_CMP: begin
				if (state_q == lfu_pkg::S_UP_RD && !sts.pos_zero) begin
					state_d = lfu_pkg::S_UP_CMP;
				end else if (state_q == lfu_pkg::S_UP_CMP && sts.up_before) begin
					state_d = lfu_pkg::S_UP_RD;
				end else if (sts.moved || !sts.remove) begin
					state_d = lfu_pkg::S_TOP;
				end else begin
					state_d = lfu_pkg::S_DN_RD;
				end
			end
			lfu_pkg::S_DN_RD: begin
				state_d = sts.left_in ? lfu_pkg::S_DN_CMP : lfu_pkg::S_TOP;
			end
			lfu_pkg::S_DN_CMP: begin
				state_d = sts.down_before ? lfu_pkg::S_DN_RD : lfu_pkg::S_TOP;
			end
			lfu_pkg::S_TOP: state_d = lfu_pkg::S_OUT;
			lfu_pkg::S_OUT: begin
				if (sts.out_free) state_d = lfu_pkg::S_IDLE;
			end
			default: state_d = lfu_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			lfu_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			lfu_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.hit = 1'b1;
				end else if (sts.miss) begin
					if (sts.remove) begin
						cmd.status_wr   = 1'b1;
						cmd.status_code = lfu_pkg::ST_ABSENT;
					end else if (sts.full) begin
						cmd.status_wr   = 1'b1;
						cmd.status_code = lfu_pkg::ST_FULL;
					end else if (sts.exhausted) begin
						cmd.status_wr   = 1'b1;
						cmd.status_code = lfu_pkg::ST_EXHAUSTED;
					end else begin
						cmd.insert = 1'b1;
					end
				end
			end
			lfu_pkg::S_RM_RD: cmd.rm_read = 1'b1;
			lfu_pkg::S_RM_LD: cmd.rm_load = 1'b1;
			lfu_pkg::S_UP_RD, lfu_pkg::S_UP_CMP: begin
				if (state_q == lfu_pkg::S_UP_RD && !sts.pos_zero) begin
					cmd.up_read = 1'b1;
				end else if (state_q == lfu_pkg::S_UP_CMP && sts.up_before) begin
					cmd.up_move = 1'b1;
				end else if (sts.moved || !sts.remove) begin
					cmd.place = 1'b1;
				end
			end
			lfu_pkg::S_DN_RD: begin
				if (sts.left_in) begin
					cmd.down_read = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			lfu_pkg::S_DN_CMP: begin
				if (sts.down_before) begin
					cmd.down_move = 1'b1;
				end else begin
					cmd.place = 1'b1;
				end
			end
			lfu_pkg::S_TOP: cmd.top_read = 1'b1;
			lfu_pkg::S_OUT: begin
				cmd.top_read = 1'b1;
				cmd.out_load = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

	// a result is loaded only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending result");

	// an item is taken only when nothing is in flight
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == lfu_pkg::S_SCAN)
		else $error("accepted item did not start a scan");

	// the heap is touched by one datapath action at a time
	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.up_move, cmd.down_move, cmd.place, cmd.insert, cmd.rm_read}))
		else $error("conflicting heap commands");

endmodule

`default_nettype wire

// ----- rtl/lfu_dpath.sv -----
`default_nettype none

module lfu_dpath #(
	parameter int CAPACITY = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire lfu_pkg::cmd_t cmd,
	output lfu_pkg::sts_t sts,
	input  wire  [0:0]    s_tuser,
	input  wire  [7:0]    s_tdata,
	output logic          m_tvalid,
	input  wire           m_tready,
	output logic [39:0]   m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int TW = $clog2(CAPACITY + 1);
	localparam int CW = AW + 2;

	// heap storage
	lfu_pkg::entry_t mem [CAPACITY];
	lfu_pkg::entry_t rdata_a_q;
	lfu_pkg::entry_t rdata_b_q;
	logic [AW-1:0]   rd_addr_a;
	logic [AW-1:0]   rd_addr_b;
	logic            wr_en;
	lfu_pkg::entry_t wr_data;

	// operation registers
	logic            func_q;
	logic [7:0]      id_q;
	logic [TW-1:0]   total_q;
	logic [31:0]     next_stamp_q;
	logic [TW-1:0]   scan_q;
	logic            chk_vld_q;
	logic [AW-1:0]   chk_idx_q;
	logic [AW-1:0]   pos_q;
	lfu_pkg::entry_t mov_q;
	logic            moved_q;
	logic [1:0]      status_q;
	logic [15:0]     count_q;

	// output register
	logic            out_vld_q;
	logic [1:0]      out_status_q;
	logic [15:0]     out_count_q;
	logic [7:0]      out_top_q;
	logic            out_top_vld_q;
	logic [5:0]      out_occ_q;

	// index arithmetic
	logic [CW-1:0]   left;
	logic [CW-1:0]   right;
	logic [AW-1:0]   parent;
	logic            right_in;
	logic            take_right;
	lfu_pkg::entry_t pick;
	logic [AW-1:0]   pick_idx;
	logic [15:0]     hit_count;

	assign left       = {1'b0, pos_q, 1'b1};
	assign right      = left + CW'(1);
	assign parent     = (pos_q - AW'(1)) >> 1;
	assign right_in   = right < CW'(total_q);
	assign take_right = right_in && lfu_pkg::key_before(rdata_b_q, rdata_a_q);
	assign pick       = take_right ? rdata_b_q : rdata_a_q;
	assign pick_idx   = take_right ? right[AW-1:0] : left[AW-1:0];
	assign hit_count  = (rdata_a_q.count == lfu_pkg::COUNT_MAX) ? lfu_pkg::COUNT_MAX
	                                                            : rdata_a_q.count + 16'd1;

	// select read addresses
	always_comb begin
		rd_addr_a = '0;
		priority if (cmd.scan) begin
			rd_addr_a = scan_q[AW-1:0];
		end else if (cmd.rm_read) begin
			rd_addr_a = AW'(total_q - TW'(1));
		end else if (cmd.up_read) begin
			rd_addr_a = parent;
		end else if (cmd.down_read) begin
			rd_addr_a = left[AW-1:0];
		end else if (cmd.top_read) begin
			rd_addr_a = '0;
		end
		rd_addr_b = right[AW-1:0];
	end

	// select write data
	always_comb begin
		wr_en   = cmd.up_move | cmd.down_move | cmd.place;
		wr_data = mov_q;
		priority if (cmd.up_move) begin
			wr_data = rdata_a_q;
		end else if (cmd.down_move) begin
			wr_data = pick;
		end
	end

	// memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) mem[pos_q] <= wr_data;
		rdata_a_q <= mem[rd_addr_a];
		rdata_b_q <= mem[rd_addr_b];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			next_stamp_q <= '0;
			scan_q       <= '0;
			chk_vld_q    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_q    <= '0;
				chk_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_q < total_q) begin
					scan_q    <= scan_q + TW'(1);
					chk_vld_q <= 1'b1;
				end else begin
					chk_vld_q <= 1'b0;
				end
			end
			if (cmd.insert) begin
				total_q      <= total_q + TW'(1);
				next_stamp_q <= next_stamp_q + 32'd1;
			end else if (cmd.rm_read) begin
				total_q <= total_q - TW'(1);
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= s_tuser[0];
			id_q     <= s_tdata;
			status_q <= lfu_pkg::ST_OK;
			count_q  <= '0;
		end
		if (cmd.scan) chk_idx_q <= scan_q[AW-1:0];
		if (cmd.status_wr) status_q <= cmd.status_code;
		if (cmd.hit) begin
			pos_q   <= chk_idx_q;
			moved_q <= 1'b0;
			if (func_q == lfu_pkg::FUNC_TOUCH) begin
				mov_q   <= '{id: rdata_a_q.id, count: hit_count, stamp: rdata_a_q.stamp};
				count_q <= hit_count;
			end
		end
		if (cmd.insert) begin
			pos_q   <= total_q[AW-1:0];
			moved_q <= 1'b0;
			mov_q   <= '{id: id_q, count: 16'd1, stamp: next_stamp_q};
			count_q <= 16'd1;
		end
		if (cmd.rm_load) mov_q <= rdata_a_q;
		if (cmd.up_move) begin
			pos_q   <= parent;
			moved_q <= 1'b1;
		end
		if (cmd.down_move) pos_q <= pick_idx;
		if (cmd.out_load) begin
			out_status_q  <= status_q;
			out_count_q   <= count_q;
			out_top_q     <= (total_q != '0) ? rdata_a_q.id : 8'd0;
			out_top_vld_q <= total_q != '0;
			out_occ_q     <= 6'(total_q);
		end
	end

	// status to the controller
	always_comb begin
		sts.hit         = chk_vld_q && (rdata_a_q.id == id_q);
		sts.miss        = !chk_vld_q && (scan_q >= total_q);
		sts.full        = total_q == TW'(CAPACITY);
		sts.exhausted   = next_stamp_q == lfu_pkg::STAMP_LAST;
		sts.remove      = func_q == lfu_pkg::FUNC_REMOVE;
		sts.pos_zero    = pos_q == '0;
		sts.pos_is_last = TW'(pos_q) == total_q;
		sts.up_before   = lfu_pkg::key_before(mov_q, rdata_a_q);
		sts.left_in     = left < CW'(total_q);
		sts.down_before = lfu_pkg::key_before(pick, mov_q);
		sts.moved       = moved_q;
		sts.out_free    = !out_vld_q || m_tready;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_occ_q, out_top_vld_q, out_top_q, out_count_q, out_status_q};

	// occupancy stays within capacity
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(CAPACITY))
		else $error("occupancy beyond capacity");

	// every heap write lands inside the occupied range
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (TW'(pos_q) < total_q))
		else $error("heap write outside occupied slots");

	// an insert grows the heap by one and never issues the last stamp
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> (total_q == $past(total_q) + TW'(1)) &&
		               ($past(next_stamp_q) != lfu_pkg::STAMP_LAST))
		else $error("insert bookkeeping wrong");

endmodule

`default_nettype wire

// ----- rtl/lfu_priority_heap.sv -----
// LFU priority heap: a binary min-heap of up to CAPACITY ids, ordered by use
// count, earliest arrival first on equal counts.
// Input channel s_*: s_tuser[0] is the operation (0 touch, 1 remove), s_tdata
// the 8-bit id. A touch counts up a present id or inserts a new one; a remove
// deletes it. Every item gives exactly one result item on m_*.
// Each item runs alone: it is accepted, then a linear scan of the occupied
// slots for the id reads one slot per cycle through a heap memory read port.
// A remove then fetches the last entry. Next comes a sift, a read and a compare
// per heap level, then a write to place the entry; a remove that does not move
// up makes the upward check before it sifts down. Last come a root read and the
// output load.
// Results sit in an output register; s_tready returns as soon as the result is
// loaded, so the next item is taken while the result waits. A stalled m_tready
// holds the result and, once the next item is done, holds that item's work.
// Reset (arst_n low) empties the heap and restarts arrival stamps at zero;
// no clearing pass is needed since unoccupied slots are never used.
`default_nettype none

module lfu_priority_heap #(
	parameter int CAPACITY = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [7:0] id
	input  wire  [0:0]  s_tuser,  // [0] func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata   // [1:0] status, [17:2] id_count, [25:18] top_id,
	                              // [26] top_valid, [32:27] occupancy, rest zero
);

	lfu_pkg::cmd_t cmd;
	lfu_pkg::sts_t sts;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfu_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- tb/sv/lfu_heap_checker.sv -----
`default_nettype none

module lfu_heap_checker #(
	parameter int CAPACITY = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] id
	input  wire [0:0]  s_tuser,   // [0] func
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [39:0] m_tdata,   // [1:0] status, [17:2] id_count, [25:18] top_id,
	                              // [26] top_valid, [32:27] occupancy, rest zero
	output int         mismatches,
	output int         pending,
	output int         results_seen,
	output int         full_refusals,
	output int         absent_removes,
	output int         saturated_touches,
	output int         peak_occupancy
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 200;

	// one result item, status in the low bits
	typedef struct packed {
		logic [6:0]  spare;
		logic [5:0]  occupancy;
		logic        top_valid;
		logic [7:0]  top_id;
		logic [15:0] id_count;
		logic [1:0]  status;
	} heap_result_t;

	// shadow heap
	logic [7:0]  slot_id    [CAPACITY];
	logic [15:0] slot_count [CAPACITY];
	logic [31:0] slot_stamp [CAPACITY];
	int          held;
	logic [31:0] stamp_next;

	heap_result_t heap_results_due[$];

	function automatic bit precedes(input int a, input int b);
		if (slot_count[a] != slot_count[b])
			return slot_count[a] < slot_count[b];
		return slot_stamp[a] < slot_stamp[b];
	endfunction

	function automatic void exchange(input int a, input int b);
		logic [7:0]  tid;
		logic [15:0] tcount;
		logic [31:0] tstamp;
		tid = slot_id[a];
		tcount = slot_count[a];
		tstamp = slot_stamp[a];
		slot_id[a] = slot_id[b];
		slot_count[a] = slot_count[b];
		slot_stamp[a] = slot_stamp[b];
		slot_id[b] = tid;
		slot_count[b] = tcount;
		slot_stamp[b] = tstamp;
	endfunction

	function automatic void bubble_up(input int p);
		int parent;
		while (p > 0 && p < held) begin
			parent = (p - 1) / 2;
			if (!precedes(p, parent))
				break;
			exchange(p, parent);
			p = parent;
		end
	endfunction

	function automatic void bubble_down(input int p);
		int lchild;
		int pick;
		while (p < held) begin
			lchild = 2 * p + 1;
			if (lchild >= held)
				break;
			pick = lchild;
			if (lchild + 1 < held && precedes(lchild + 1, lchild))
				pick = lchild + 1;
			if (!precedes(pick, p))
				break;
			exchange(p, pick);
			p = pick;
		end
	endfunction

	function automatic bit locate(input logic [7:0] id, output int where);
		where = 0;
		for (int i = 0; i < held; i++) begin
			if (slot_id[i] == id) begin
				where = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void clear_heap();
		for (int i = 0; i < CAPACITY; i++) begin
			slot_id[i] = '0;
			slot_count[i] = '0;
			slot_stamp[i] = '0;
		end
		held = 0;
		stamp_next = '0;
	endfunction

	// apply one operation to the shadow heap and build its result
	function automatic heap_result_t lfu_update(input logic func, input logic [7:0] id);
		heap_result_t r;
		int where;
		int last;
		r = '0;
		r.status = lfu_pkg::ST_OK;
		if (func == lfu_pkg::FUNC_TOUCH) begin
			if (locate(id, where)) begin
				if (slot_count[where] == lfu_pkg::COUNT_MAX)
					saturated_touches++;
				else
					slot_count[where] = slot_count[where] + 16'd1;
				r.id_count = slot_count[where];
				bubble_down(where);
			end else if (held >= CAPACITY) begin
				r.status = lfu_pkg::ST_FULL;
				full_refusals++;
			end else if (stamp_next == lfu_pkg::STAMP_LAST) begin
				r.status = lfu_pkg::ST_EXHAUSTED;
			end else begin
				where = held;
				slot_id[where] = id;
				slot_count[where] = 16'd1;
				slot_stamp[where] = stamp_next;
				stamp_next = stamp_next + 32'd1;
				held++;
				r.id_count = 16'd1;
				bubble_up(where);
			end
		end else begin
			if (locate(id, where)) begin
				// move the last entry into the hole, then restore order both ways
				last = held - 1;
				if (where != last) begin
					slot_id[where] = slot_id[last];
					slot_count[where] = slot_count[last];
					slot_stamp[where] = slot_stamp[last];
				end
				slot_id[last] = '0;
				slot_count[last] = '0;
				slot_stamp[last] = '0;
				held = last;
				if (where < held) begin
					bubble_up(where);
					bubble_down(where);
				end
			end else begin
				r.status = lfu_pkg::ST_ABSENT;
				absent_removes++;
			end
		end
		r.top_id = (held > 0) ? slot_id[0] : 8'd0;
		r.top_valid = (held > 0);
		r.occupancy = held[5:0];
		if (held > peak_occupancy)
			peak_occupancy = held;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
		mismatches++;
	endtask

	// predict on every accepted input item, compare every accepted result item
	always @(posedge clk or negedge arst_n) begin : monitor
		heap_result_t seen;
		heap_result_t want;
		if (!arst_n) begin
			clear_heap();
			heap_results_due.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				heap_results_due.insert(heap_results_due.size(),
					lfu_update(s_tuser[0], s_tdata));
			if (m_tvalid && m_tready) begin
				seen = heap_result_t'(m_tdata);
				results_seen++;
				if (heap_results_due.size() == 0) begin
					report_mismatch("with no item outstanding", m_tdata, 0);
				end else begin
					want = heap_results_due[0];
					heap_results_due.delete(0);
					if (seen.status !== want.status)
						report_mismatch("status", seen.status, want.status);
					if (seen.id_count !== want.id_count)
						report_mismatch("id_count", seen.id_count, want.id_count);
					if (seen.top_id !== want.top_id)
						report_mismatch("top_id", seen.top_id, want.top_id);
					if (seen.top_valid !== want.top_valid)
						report_mismatch("top_valid", seen.top_valid, want.top_valid);
					if (seen.occupancy !== want.occupancy)
						report_mismatch("occupancy", seen.occupancy, want.occupancy);
					if (seen.spare !== want.spare)
						report_mismatch("upper padding", seen.spare, want.spare);
				end
			end
			pending <= heap_results_due.size();
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_lfu_priority_heap.sv -----
`default_nettype none

module tb_lfu_priority_heap;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY        = 32;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_ITEMS    = 500;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 64;
	localparam int IDLE_LIMIT      = 4000;
	localparam int HOT_TOUCHES     = 40;
	localparam logic [7:0] HOT_ID  = 8'h3C;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] id
	logic [0:0]  s_tuser = '0;   // [0] func
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [39:0] m_tdata;        // [1:0] status, [17:2] id_count, [25:18] top_id,
	                             // [26] top_valid, [32:27] occupancy, rest zero

	int mismatches;
	int pending;
	int results_seen;
	int full_refusals;
	int absent_removes;
	int saturated_touches;
	int peak_occupancy;

	// stimulus shaping, written by the sender process
	int ready_pct = 100;
	int hold_requests = 0;
	int max_gap = 0;
	int burst_left = 0;
	int items_sent = 0;

	always #6 clk = ~clk;

	lfu_priority_heap #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	lfu_heap_checker #(
		.CAPACITY(CAPACITY)
	) heap_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.mismatches       (mismatches),
		.pending          (pending),
		.results_seen     (results_seen),
		.full_refusals    (full_refusals),
		.absent_removes   (absent_removes),
		.saturated_touches(saturated_touches),
		.peak_occupancy   (peak_occupancy)
	);

	// receiver: random ready runs, plus a long hold-off on request
	initial begin : receiver
		int holds_done;
		int run;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				run = $urandom_range(1, 6);
				m_tready <= ($urandom_range(0, 99) < ready_pct);
				repeat (run - 1) @(posedge clk);
			end
		end
	end

	// watchdog: end the run when no item moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL lfu_priority_heap");
		$finish;
	end

	// offer one item, opening a new burst after a random gap when the old one runs out
	task automatic offer(input logic func, input logic [7:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= id;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// stop offering until every outstanding result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : sender
		logic [7:0] pool [64];
		int pool_size;
		int remove_pct;
		int episode_len;
		int episode;
		int random_sent;
		int pick;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty heap, id extremes, ties, removes from root, middle and tail
		ready_pct <= 70;
		max_gap = 3;
		offer(lfu_pkg::FUNC_REMOVE, 8'h00);
		offer(lfu_pkg::FUNC_TOUCH, 8'h00);
		offer(lfu_pkg::FUNC_TOUCH, 8'hFF);
		offer(lfu_pkg::FUNC_TOUCH, 8'h00);
		offer(lfu_pkg::FUNC_TOUCH, 8'hFF);
		offer(lfu_pkg::FUNC_REMOVE, 8'h80);
		offer(lfu_pkg::FUNC_REMOVE, 8'h00);
		offer(lfu_pkg::FUNC_REMOVE, 8'hFF);
		offer(lfu_pkg::FUNC_REMOVE, 8'hFF);
		offer(lfu_pkg::FUNC_TOUCH, 8'h55);
		offer(lfu_pkg::FUNC_TOUCH, 8'hAA);
		offer(lfu_pkg::FUNC_TOUCH, 8'h01);
		offer(lfu_pkg::FUNC_TOUCH, 8'hFE);
		offer(lfu_pkg::FUNC_TOUCH, 8'h55);
		offer(lfu_pkg::FUNC_TOUCH, 8'h01);
		offer(lfu_pkg::FUNC_REMOVE, 8'hAA);
		offer(lfu_pkg::FUNC_REMOVE, 8'hFE);
		offer(lfu_pkg::FUNC_REMOVE, 8'h55);
		offer(lfu_pkg::FUNC_REMOVE, 8'h01);
		drain();

		// one entry touched over and over at full rate, then a newcomer behind it
		ready_pct <= 100;
		max_gap = 0;
		offer(lfu_pkg::FUNC_TOUCH, HOT_ID);
		repeat (HOT_TOUCHES) offer(lfu_pkg::FUNC_TOUCH, HOT_ID);
		offer(lfu_pkg::FUNC_TOUCH, 8'hC3);
		offer(lfu_pkg::FUNC_TOUCH, HOT_ID);
		offer(lfu_pkg::FUNC_TOUCH, 8'hC3);
		offer(lfu_pkg::FUNC_REMOVE, HOT_ID);
		offer(lfu_pkg::FUNC_REMOVE, 8'hC3);
		drain();

		// random episodes over id pools of varied size and remove mix
		episode = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (episode == 0) begin
				// a pool larger than capacity and no removes drawn from the pool
				pool_size = 40;
				remove_pct = 0;
				episode_len = 48;
			end else begin
				case ($urandom_range(0, 4))
					0: pool_size = 3;
					1: pool_size = 10;
					2: pool_size = 24;
					3: pool_size = 36;
					default: pool_size = 64;
				endcase
				remove_pct = $urandom_range(5, 50);
				episode_len = $urandom_range(20, 60);
			end
			for (int i = 0; i < pool_size; i++)
				pool[i] = (episode == 0) ? 8'(i * 7 + 3) : 8'($urandom_range(0, 255));
			case ($urandom_range(0, 3))
				0: ready_pct <= 100;
				1: ready_pct <= 85;
				2: ready_pct <= 50;
				default: ready_pct <= 20;
			endcase
			max_gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);

			// long receiver hold-off while items keep coming
			if (episode == 2 || episode == 7)
				hold_requests <= hold_requests + 1;

			for (int n = 0; n < episode_len; n++) begin
				if ($urandom_range(0, 99) < 8) begin
					offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end else begin
					pick = $urandom_range(0, pool_size - 1);
					offer(($urandom_range(0, 99) < remove_pct) ? lfu_pkg::FUNC_REMOVE
						: lfu_pkg::FUNC_TOUCH, pool[pick]);
				end
				random_sent++;
			end

			if (episode == 1 || $urandom_range(0, 99) < 30)
				drain();
			episode++;
		end

		// wait out every result, then a quiet stretch for anything unexpected
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d random) through %0d results; peak occupancy %0d of %0d.",
			items_sent, random_sent, results_seen, peak_occupancy, CAPACITY);
		$display("Saw %0d full-heap refusals, %0d removes of absent ids, %0d touches at saturation.",
			full_refusals, absent_removes, saturated_touches);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS lfu_priority_heap");
		end else begin
			$display("FAIL lfu_priority_heap");
		end
		$finish;
	end

endmodule

`default_nettype wire
